[design/rtot_pkg.sv]
// Shared types, constants and helper functions for the root tuple obstruction test.
// No dependencies; every other file in the project but rtot_rsp_if takes names from here.
package rtot_pkg;

   localparam int ROOT_BITS = 9;
   // Odd-part subtractive gcd of two ROOT_BITS values ends within this many steps
   localparam int GCD_STEPS = 2 * ROOT_BITS;

   typedef logic [ROOT_BITS-1:0] root_type;

   typedef struct packed {
      root_type x;
      root_type y;
   } gcd_pair_type;

   typedef struct packed {
      gcd_pair_type ab;
      gcd_pair_type cd;
      root_type     e;
   } gcd_lanes_type;

   // Strip trailing zero bits; zero stays zero
   function automatic root_type odd_part(root_type x);
      root_type v;
      v = x;
      for (int i = 0; i < ROOT_BITS - 1; i++) begin
         if (v != '0 && !v[0]) begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

   // One subtractive step on odd-or-zero operands; done once y is zero, result in x
   function automatic gcd_pair_type gcd_step(gcd_pair_type p);
      gcd_pair_type r;
      r = p;
      if (p.y == '0) begin
         r = p;
      end else if (p.x == '0) begin
         r.x = p.y;
         r.y = '0;
      end else if (p.x == p.y) begin
         r.x = p.x;
         r.y = '0;
      end else if (p.x < p.y) begin
         r.x = p.x;
         r.y = odd_part(p.y - p.x);
      end else begin
         r.x = p.y;
         r.y = odd_part(p.x - p.y);
      end
      return r;
   endfunction

endpackage

[design/rtot_req_if.sv]
// Input channel: one root tuple per item, valid/ready handshake.
// Depends on rtot_pkg for the root type.
interface rtot_req_if;
   logic               valid;
   logic               ready;
   rtot_pkg::root_type root_a;
   rtot_pkg::root_type root_b;
   rtot_pkg::root_type root_c;
   rtot_pkg::root_type root_d;
   rtot_pkg::root_type root_e;

   modport source (output valid, root_a, root_b, root_c, root_d, root_e, input ready);
   modport sink   (input valid, root_a, root_b, root_c, root_d, root_e, output ready);
endinterface

[design/rtot_rsp_if.sv]
// Result channel: test flags and obstruction value per item, valid/ready handshake.
// No package dependencies.
interface rtot_rsp_if;
   logic               valid;
   logic               ready;
   logic               ordered;
   logic               primitive_normalized;
   logic               obstruction_zero;
   logic               reflection_symmetric;
   logic signed [62:0] obstruction_value;

   modport source (output valid, ordered, primitive_normalized, obstruction_zero,
                   reflection_symmetric, obstruction_value, input ready);
   modport sink   (input valid, ordered, primitive_normalized, obstruction_zero,
                   reflection_symmetric, obstruction_value, output ready);
endinterface

[design/root_tuple_obstruction_test.sv]
// Root tuple obstruction test, top level.
// Throughput one item per cycle while no result waits untaken at the output.
// The gcd chain sets the pipeline depth: three phases of 18 subtractive steps, one per stage.
// The whole pipeline holds while a result waits untaken; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; payload registers keep no reset.
// Depends on rtot_pkg, rtot_req_if and rtot_rsp_if.
module root_tuple_obstruction_test (
   input  logic        clock,
   input  logic        reset,
   rtot_req_if.sink    req_ch,
   rtot_rsp_if.source  rsp_ch
);

   localparam int NG  = 3 * rtot_pkg::GCD_STEPS;
   localparam int DLY = NG - 10;
   localparam int LAT = NG + 2;

   typedef struct packed {
      logic ordered;
      logic norm;
      logic sym;
      logic all_even;
   } flag_type;

   typedef struct packed {
      flag_type           flags;
      logic               zero;
      logic signed [62:0] value;
   } result_type;

   logic adv;
   logic [LAT:1] vld_ff;
   logic [LAT:1] vld_in;

   // Advance everything unless the output holds an untaken item
   assign adv          = !(rsp_ch.valid && !rsp_ch.ready);
   assign req_ch.ready = adv;

   assign vld_in = {vld_ff[LAT-1:1], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: order, normalization, reflection and parity checks; pair products and sums
   rtot_pkg::root_type ra, rb, rc, rd, re;
   assign ra = req_ch.root_a;
   assign rb = req_ch.root_b;
   assign rc = req_ch.root_c;
   assign rd = req_ch.root_d;
   assign re = req_ch.root_e;

   flag_type flags_in;
   logic signed [9:0] rs [4];
   logic signed [9:0] rf [4];
   logic done;

   always_comb begin
      rs[0] = $signed({1'b0, ra});
      rs[1] = $signed({1'b0, rb});
      rs[2] = $signed({1'b0, rc});
      rs[3] = $signed({1'b0, rd});
      for (int i = 0; i < 4; i++) begin
         rf[i] = $signed({1'b0, re}) - rs[3-i];
      end
      flags_in.ordered  = (ra != '0) && (ra < rb) && (rb < rc) && (rc < rd) && (rd < re);
      flags_in.sym      = ({1'b0, re} == 10'(ra) + 10'(rd)) &&
                          ({1'b0, re} == 10'(rb) + 10'(rc));
      flags_in.all_even = !(ra[0] | rb[0] | rc[0] | rd[0] | re[0]);
      flags_in.norm     = 1'b1;
      done              = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!done && rs[i] != rf[i]) begin
            flags_in.norm = rs[i] < rf[i];
            done          = 1'b1;
         end
      end
   end

   flag_type fl_ff [1:10];
   logic [17:0] p1_1_ff, p2_1_ff;
   logic [9:0]  q1_1_ff, q2_1_ff;
   rtot_pkg::root_type e_1_ff, e_2_ff, e_3_ff;
   rtot_pkg::gcd_lanes_type g_ff [0:NG];
   rtot_pkg::gcd_lanes_type g_init_in;

   always_comb begin
      g_init_in.ab.x = rtot_pkg::odd_part(ra);
      g_init_in.ab.y = rtot_pkg::odd_part(rb);
      g_init_in.cd.x = rtot_pkg::odd_part(rc);
      g_init_in.cd.y = rtot_pkg::odd_part(rd);
      g_init_in.e    = rtot_pkg::odd_part(re);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fl_ff[1] <= flags_in;
         p1_1_ff  <= 18'(ra) * 18'(rb);
         p2_1_ff  <= 18'(rc) * 18'(rd);
         q1_1_ff  <= 10'(ra) + 10'(rb);
         q2_1_ff  <= 10'(rc) + 10'(rd);
         e_1_ff   <= re;
         g_ff[0]  <= g_init_in;
      end
   end

   // Carry flags alongside the arithmetic stages
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 2; k <= 10; k++) begin
            fl_ff[k] <= fl_ff[k-1];
         end
      end
   end

   // Stage 2: cross products of the two pairs
   logic [10:0] e1_2_ff, e1_3_ff, e1_4_ff;
   logic [19:0] q1q2_2_ff;
   logic [27:0] p1q2_2_ff, p2q1_2_ff;
   logic [35:0] p1p2_2_ff;
   logic [17:0] p1_2_ff, p2_2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_2_ff   <= 11'(q1_1_ff) + 11'(q2_1_ff);
         q1q2_2_ff <= 20'(q1_1_ff) * 20'(q2_1_ff);
         p1q2_2_ff <= 28'(p1_1_ff) * 28'(q2_1_ff);
         p2q1_2_ff <= 28'(p2_1_ff) * 28'(q1_1_ff);
         p1p2_2_ff <= 36'(p1_1_ff) * 36'(p2_1_ff);
         p1_2_ff   <= p1_1_ff;
         p2_2_ff   <= p2_1_ff;
         e_2_ff    <= e_1_ff;
      end
   end

   // Stage 3: symmetric sums of the four inner roots
   logic [20:0] e2_3_ff, e2_4_ff;
   logic [28:0] e3_3_ff, e3_4_ff;
   logic [35:0] e4_3_ff, e4_4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_3_ff <= e1_2_ff;
         e2_3_ff <= 21'(p1_2_ff) + 21'(p2_2_ff) + 21'(q1q2_2_ff);
         e3_3_ff <= 29'(p1q2_2_ff) + 29'(p2q1_2_ff);
         e4_3_ff <= p1p2_2_ff;
         e_3_ff  <= e_2_ff;
      end
   end

   // Stage 4: scale the inner sums by the largest root
   logic [19:0] ee1_4_ff;
   logic [29:0] ee2_4_ff;
   logic [37:0] ee3_4_ff;
   logic [44:0] ee4_4_ff;
   rtot_pkg::root_type e_4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ee1_4_ff <= 20'(e_3_ff) * 20'(e1_3_ff);
         ee2_4_ff <= 30'(e_3_ff) * 30'(e2_3_ff);
         ee3_4_ff <= 38'(e_3_ff) * 38'(e3_3_ff);
         ee4_4_ff <= 45'(e_3_ff) * 45'(e4_3_ff);
         e1_4_ff  <= e1_3_ff;
         e2_4_ff  <= e2_3_ff;
         e3_4_ff  <= e3_3_ff;
         e4_4_ff  <= e4_3_ff;
         e_4_ff   <= e_3_ff;
      end
   end

   // Stage 5: elementary symmetric sums s1..s5
   logic [11:0] s1_5_ff;
   logic [21:0] s2_5_ff;
   logic [30:0] s3_5_ff;
   logic [38:0] s4_5_ff;
   logic [44:0] s5_5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_5_ff <= 12'(e1_4_ff) + 12'(e_4_ff);
         s2_5_ff <= 22'(e2_4_ff) + 22'(ee1_4_ff);
         s3_5_ff <= 31'(e3_4_ff) + 31'(ee2_4_ff);
         s4_5_ff <= 39'(e4_4_ff) + 39'(ee3_4_ff);
         s5_5_ff <= ee4_4_ff;
      end
   end

   // Stage 6: first round of monomial products
   logic [23:0] s1sq_6_ff;
   logic [42:0] s1s3_6_ff, s1s3_7_ff;
   logic [43:0] s2sq_6_ff, s2sq_7_ff;
   logic [38:0] s4_6_ff, s4_7_ff;
   logic [52:0] s2s3_6_ff, s2s3_7_ff;
   logic [11:0] s1_6_ff, s1_7_ff, s1_8_ff, s1_9_ff;
   logic [21:0] s2_6_ff;
   logic [44:0] s5_6_ff, s5_7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1sq_6_ff <= 24'(s1_5_ff) * 24'(s1_5_ff);
         s1s3_6_ff <= 43'(s1_5_ff) * 43'(s3_5_ff);
         s2sq_6_ff <= 44'(s2_5_ff) * 44'(s2_5_ff);
         s4_6_ff   <= s4_5_ff;
         s2s3_6_ff <= 53'(s2_5_ff) * 53'(s3_5_ff);
         s1_6_ff   <= s1_5_ff;
         s2_6_ff   <= s2_5_ff;
         s5_6_ff   <= s5_5_ff;
      end
   end

   // Stage 7: fourth power of s1 and s1^2 s2
   logic [47:0] s1p4_7_ff;
   logic [45:0] s1sqs2_7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1p4_7_ff   <= 48'(s1sq_6_ff) * 48'(s1sq_6_ff);
         s1sqs2_7_ff <= 46'(s1sq_6_ff) * 46'(s2_6_ff);
         s1s3_7_ff   <= s1s3_6_ff;
         s2sq_7_ff   <= s2sq_6_ff;
         s4_7_ff     <= s4_6_ff;
         s2s3_7_ff   <= s2s3_6_ff;
         s5_7_ff     <= s5_6_ff;
         s1_7_ff     <= s1_6_ff;
      end
   end

   // Stage 8: weighted partial sums; P = s1 * Q + R
   logic signed [57:0] t1_8_ff, t2_8_ff, r_8_ff, r_9_ff, q_9_ff;
   logic signed [57:0] t1_in, t2_in, r_in;

   always_comb begin
      t1_in = 58'sd6 * $signed(58'(s1sqs2_7_ff)) - $signed(58'(s1p4_7_ff))
            - 58'sd7 * $signed(58'(s1s3_7_ff));
      t2_in = 58'sd8 * ($signed(58'(s4_7_ff)) - $signed(58'(s2sq_7_ff)));
      r_in  = 58'sd12 * $signed(58'(s2s3_7_ff)) - 58'sd24 * $signed(58'(s5_7_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_8_ff <= t1_in;
         t2_8_ff <= t2_in;
         r_8_ff  <= r_in;
         s1_8_ff <= s1_7_ff;
      end
   end

   // Stage 9: Q
   always_ff @(posedge clock) begin
      if (adv) begin
         q_9_ff  <= t1_8_ff + t2_8_ff;
         r_9_ff  <= r_8_ff;
         s1_9_ff <= s1_8_ff;
      end
   end

   // Stage 10: s1 * Q, kept modulo 2^64
   logic signed [70:0] sq_full;
   logic signed [63:0] sq_10_ff;
   logic signed [57:0] r_10_ff;

   assign sq_full = $signed({1'b0, s1_9_ff}) * q_9_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_10_ff <= $signed(sq_full[63:0]);
         r_10_ff  <= r_9_ff;
      end
   end

   // Stage 11: final sum and zero test
   logic signed [63:0] p_in;
   result_type res_in;

   assign p_in = sq_10_ff + 64'(r_10_ff);

   always_comb begin
      res_in.flags = fl_ff[10];
      res_in.zero  = (p_in == '0);
      res_in.value = $signed(p_in[62:0]);
   end

   result_type res_11_ff;
   result_type dly_ff [0:DLY-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         res_11_ff <= res_in;
         dly_ff[0] <= res_11_ff;
         for (int k = 1; k < DLY; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   // Gcd chain: (a,b) and (c,d), then the two results, then with e
   rtot_pkg::gcd_lanes_type g_in [1:NG];

   for (genvar k = 1; k <= NG; k++) begin : g_stage
      rtot_pkg::gcd_lanes_type src;
      always_comb begin
         src = g_ff[k-1];
         if (k - 1 == rtot_pkg::GCD_STEPS) begin
            src.ab.y = g_ff[k-1].cd.x;
            src.cd.x = g_ff[k-1].e;
            src.cd.y = '0;
         end else if (k - 1 == 2 * rtot_pkg::GCD_STEPS) begin
            src.ab.y = g_ff[k-1].cd.x;
            src.cd.x = '0;
            src.cd.y = '0;
         end
         g_in[k]    = src;
         g_in[k].ab = rtot_pkg::gcd_step(src.ab);
         g_in[k].cd = rtot_pkg::gcd_step(src.cd);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            g_ff[k] <= g_in[k];
         end
      end
   end

   // Output register: join gcd result with the delayed arithmetic
   result_type last;
   assign last = dly_ff[DLY-1];

   logic               ordered_ff, prim_ff, zero_ff, sym_ff;
   logic signed [62:0] value_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ordered_ff <= last.flags.ordered;
         prim_ff    <= (g_ff[NG].ab.x == rtot_pkg::root_type'(1)) && last.flags.norm
                       && !last.flags.all_even;
         zero_ff    <= last.zero;
         sym_ff     <= last.flags.sym;
         value_ff   <= last.value;
      end
   end

   assign rsp_ch.valid                = vld_ff[LAT];
   assign rsp_ch.ordered              = ordered_ff;
   assign rsp_ch.primitive_normalized = prim_ff;
   assign rsp_ch.obstruction_zero     = zero_ff;
   assign rsp_ch.reflection_symmetric = sym_ff;
   assign rsp_ch.obstruction_value    = value_ff;

endmodule

[test/tb_root_tuple_obstruction_test.sv]
// Testbench for the root tuple obstruction test: directed and random root tuples,
// results predicted in the bench and compared field by field, in order.
// Depends on rtot_pkg, rtot_req_if, rtot_rsp_if and the top level.
module tb_root_tuple_obstruction_test;

   typedef struct {
      logic               ordered;
      logic               primitive_normalized;
      logic               obstruction_zero;
      logic               reflection_symmetric;
      logic signed [62:0] obstruction_value;
   } verdict_type;

   logic clock;
   logic reset;
   int   mismatch_count = 0;
   bit   sending_done;
   bit   stall_enable;

   verdict_type pending_verdicts[$];

   rtot_req_if req_ch();
   rtot_rsp_if rsp_ch();

   root_tuple_obstruction_test dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on run length
   initial begin
      #2000000;
      $display("[root_tuple_obstruction_test] ERROR");
      $finish;
   end

   // Euclid on 32-bit values
   function automatic int unsigned gcd_of(int unsigned x, int unsigned y);
      int unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Compute the expected verdict for one tuple
   function automatic verdict_type judge_tuple(rtot_pkg::root_type ra, rtot_pkg::root_type rb,
                                               rtot_pkg::root_type rc, rtot_pkg::root_type rd,
                                               rtot_pkg::root_type re);
      verdict_type     v;
      longint          r[5];
      longint          el[6];
      longint          refl;
      longint          p;
      int unsigned     g;
      bit              norm;
      bit              decided;
      r[0] = ra; r[1] = rb; r[2] = rc; r[3] = rd; r[4] = re;
      v.ordered = r[0] > 0 && r[0] < r[1] && r[1] < r[2] && r[2] < r[3] && r[3] < r[4];
      g = 0;
      for (int i = 0; i < 5; i++) g = gcd_of(g, int'(r[i]));
      // Lexicographic compare against the reflected inner roots
      norm = 1'b1;
      decided = 1'b0;
      for (int i = 0; i < 4; i++) begin
         refl = r[4] - r[3-i];
         if (!decided && r[i] != refl) begin
            norm = r[i] < refl;
            decided = 1'b1;
         end
      end
      v.primitive_normalized = (g == 1) && norm;
      v.reflection_symmetric = (r[4] == r[0] + r[3]) && (r[4] == r[1] + r[2]);
      el[0] = 1;
      for (int k = 1; k < 6; k++) el[k] = 0;
      for (int i = 0; i < 5; i++)
         for (int k = 5; k >= 1; k--) el[k] += r[i] * el[k-1];
      p = -el[1]*el[1]*el[1]*el[1]*el[1] + 6*el[1]*el[1]*el[1]*el[2]
          - 7*el[1]*el[1]*el[3] - 8*el[1]*el[2]*el[2] + 8*el[1]*el[4]
          + 12*el[2]*el[3] - 24*el[5];
      v.obstruction_zero = (p == 0);
      v.obstruction_value = p[62:0];
      return v;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      mismatch_count++;
   endtask

   // Send one item; hold valid until accepted
   task automatic send_tuple(rtot_pkg::root_type ra, rtot_pkg::root_type rb,
                             rtot_pkg::root_type rc, rtot_pkg::root_type rd,
                             rtot_pkg::root_type re);
      req_ch.valid  <= 1'b1;
      req_ch.root_a <= ra;
      req_ch.root_b <= rb;
      req_ch.root_c <= rc;
      req_ch.root_d <= rd;
      req_ch.root_e <= re;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_verdicts.push_back(judge_tuple(ra, rb, rc, rd, re));
   endtask

   // Drop valid for a random gap after a burst
   task automatic maybe_gap(ref int burst_left);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_directed();
      int burst_left;
      burst_left = 0;
      send_tuple(0, 0, 0, 0, 0);
      send_tuple(511, 511, 511, 511, 511);
      send_tuple(1, 2, 3, 4, 5);
      send_tuple(1, 2, 3, 4, 5);
      send_tuple(2, 4, 6, 8, 10);
      send_tuple(1, 3, 4, 6, 7);
      send_tuple(507, 508, 509, 510, 511);
      send_tuple(1, 2, 4, 8, 511);
      send_tuple(5, 4, 3, 2, 1);
      send_tuple(0, 1, 2, 3, 4);
      send_tuple(3, 3, 4, 5, 6);
      send_tuple(4, 6, 7, 8, 10);
      send_tuple(256, 128, 64, 32, 16);
      send_tuple(1, 255, 256, 510, 511);
      send_tuple(170, 341, 85, 426, 255);
      send_tuple(2, 3, 5, 7, 9);
      maybe_gap(burst_left);
      send_tuple(1, 4, 5, 8, 9);
      send_tuple(3, 5, 6, 7, 9);
   endtask

   task automatic test_random(int count);
      int                 burst_left;
      int                 kind;
      rtot_pkg::root_type t[5];
      rtot_pkg::root_type tmp;
      int                 e;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            // Ordered tuple with small or full-range scale
            e = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 511) : $urandom_range(5, 40);
            do begin
               for (int i = 0; i < 4; i++)
                  t[i] = rtot_pkg::root_type'($urandom_range(1, e - 1));
               t[4] = rtot_pkg::root_type'(e);
               for (int i = 0; i < 4; i++)
                  for (int j = 0; j < 3 - i; j++)
                     if (t[j] > t[j+1]) begin
                        tmp = t[j]; t[j] = t[j+1]; t[j+1] = tmp;
                     end
            end while (!(t[0] < t[1] && t[1] < t[2] && t[2] < t[3]));
         end else if (kind < 7) begin
            // Reflection-symmetric tuple
            e = $urandom_range(6, 511);
            t[0] = rtot_pkg::root_type'($urandom_range(1, e / 2 - 1));
            t[1] = rtot_pkg::root_type'($urandom_range(t[0] + 1,
                      (e + 1) / 2 - 1 > t[0] ? (e + 1) / 2 - 1 : t[0] + 1));
            t[2] = rtot_pkg::root_type'(e - t[1]);
            t[3] = rtot_pkg::root_type'(e - t[0]);
            t[4] = rtot_pkg::root_type'(e);
         end else begin
            for (int i = 0; i < 5; i++) t[i] = rtot_pkg::root_type'($urandom_range(0, 511));
         end
         send_tuple(t[0], t[1], t[2], t[3], t[4]);
         maybe_gap(burst_left);
      end
   endtask

   // Ready stalls: long clean stretches alternating with random stalls
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!stall_enable) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(0, 99) < 60);
         if ($urandom_range(0, 49) == 0) stall_enable = !stall_enable;
      end
   end

   // Compare each accepted result with the oldest expectation
   initial begin
      verdict_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_ch.ordered !== want.ordered)
                  report_mismatch("ordered", rsp_ch.ordered, want.ordered);
               if (rsp_ch.primitive_normalized !== want.primitive_normalized)
                  report_mismatch("primitive_normalized", rsp_ch.primitive_normalized,
                                  want.primitive_normalized);
               if (rsp_ch.obstruction_zero !== want.obstruction_zero)
                  report_mismatch("obstruction_zero", rsp_ch.obstruction_zero,
                                  want.obstruction_zero);
               if (rsp_ch.reflection_symmetric !== want.reflection_symmetric)
                  report_mismatch("reflection_symmetric", rsp_ch.reflection_symmetric,
                                  want.reflection_symmetric);
               if (rsp_ch.obstruction_value !== want.obstruction_value)
                  report_mismatch("obstruction_value", rsp_ch.obstruction_value,
                                  want.obstruction_value);
            end
         end
      end
   end

   // Sequence the run
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.root_a  = '0;
      req_ch.root_b  = '0;
      req_ch.root_c  = '0;
      req_ch.root_d  = '0;
      req_ch.root_e  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(750);
      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[root_tuple_obstruction_test] OK");
      end else begin
         $display("[root_tuple_obstruction_test] ERROR");
      end
      $finish;
   end

endmodule
